FILE: rtl/core/easing_curve_unit_assert.svh
// Assertion macros for the easing curve unit.
// Included by the RTL files that check their own logic; needs nothing else.
`ifndef EASING_CURVE_UNIT_ASSERT_SVH
`define EASING_CURVE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in any cycle where ante holds
`define ECU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
        else $error("easing_curve_unit: implication check failed");

// Check that bad never holds
`define ECU_ASSERT_NEVER(lbl, clk, rst, bad) \
    lbl: assert property (@(posedge clk) disable iff (!(rst)) !(bad)) \
        else $error("easing_curve_unit: forbidden condition seen");

`else

`define ECU_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ECU_ASSERT_NEVER(lbl, clk, rst, bad)

`endif

`endif

FILE: rtl/core/ecu_pkg.sv
// Shared constants, types and helpers for the easing curve unit.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ecu_pkg;

    // Fixed-point format of the fraction t/d: 1.0 is 2^FRAC_BITS
    localparam int FRAC_BITS = 16;
    localparam int UW        = FRAC_BITS + 1;   // fraction width, holds 1.0
    localparam int DUR_W     = 16;              // time and duration width
    localparam int REM_W     = DUR_W + 1;       // divider remainder width
    localparam int VAL_W     = 16;              // begin and change width
    localparam int OUT_W     = 17;              // eased value width
    localparam int PW        = VAL_W + UW + 1;  // change * fraction product
    localparam int DLT_W     = PW - FRAC_BITS;  // rounded delta width
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [UW-1:0] FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [UW-1:0] FX_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // Curve codes
    localparam logic [MODE_W-1:0] MODE_IN_CUBIC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUT_CUBIC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INOUT_CUBIC = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INOUT_QUART = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_VALUE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_AMOUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION      = 2'd3;

    typedef logic [UW-1:0] t_frac;

    // Divider to curve stages
    typedef struct packed {
        logic  zero;
        t_frac u;
    } t_div_word;

    // Curve to scaling stages
    typedef struct packed {
        logic  zero;
        t_frac f;
    } t_curve_word;

    // Truncating fixed-point product: floor(a*b / 2^FRAC_BITS)
    function automatic t_frac fx_mul(input t_frac a, input t_frac b);
        logic [2*UW-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: UW];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ecu_div_pipe.sv
// Pipelined restoring divider: u = floor(min(t,d) * 2^FRAC_BITS / d).
// One quotient bit per stage; uses ecu_pkg.
`default_nettype none

module ecu_div_pipe
    import ecu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DUR_W-1:0] i_duration,
    input  wire logic             i_vld,
    input  wire logic [DUR_W-1:0] i_time,
    output logic                  o_rdy,
    output logic                  o_vld,
    output t_div_word             o_word,
    input  wire logic             i_rdy
);

    localparam int NBIT = FRAC_BITS + 1;

    logic [REM_W-1:0] w_dvs;

    // Input stage: saturate time, flag zero duration
    logic             r_in_vld;
    logic [REM_W-1:0] r_in_rem;
    logic             r_in_zero;
    logic             w_in_adv;

    // Bit stages
    logic             r_vld  [0:NBIT-1];
    logic [REM_W-1:0] r_rem  [0:NBIT-1];
    logic [UW-1:0]    r_q    [0:NBIT-1];
    logic             r_zero [0:NBIT-1];
    logic             w_adv  [0:NBIT-1];

    assign w_dvs    = {1'b0, i_duration};
    assign w_in_adv = ~r_in_vld | w_adv[0];
    assign o_rdy    = w_in_adv;

    // Hold valid across stalls, load when the stage advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_adv) begin
            r_in_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_vld) begin
            r_in_rem  <= (i_time > i_duration) ? w_dvs : {1'b0, i_time};
            r_in_zero <= (i_duration == '0);
        end
    end

    for (genvar k = 0; k < NBIT; k++) begin : g_bit
        logic [REM_W-1:0] w_sh;
        logic [UW-1:0]    w_qsrc;
        logic             w_vsrc;
        logic             w_zsrc;
        logic             w_ge;
        logic [REM_W-1:0] n_rem;
        logic [UW-1:0]    n_q;

        if (k == 0) begin : g_head
            // Top quotient bit: only set when t equals d
            assign w_sh   = r_in_rem;
            assign w_qsrc = '0;
            assign w_vsrc = r_in_vld;
            assign w_zsrc = r_in_zero;
        end else begin : g_tail
            // Remainder stays below d, so the shift never overflows
            assign w_sh   = {r_rem[k-1][REM_W-2:0], 1'b0};
            assign w_qsrc = r_q[k-1];
            assign w_vsrc = r_vld[k-1];
            assign w_zsrc = r_zero[k-1];
        end

        if (k == NBIT - 1) begin : g_last
            assign w_adv[k] = ~r_vld[k] | i_rdy;
        end else begin : g_mid
            assign w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end

        // Compare and subtract
        assign w_ge  = (w_sh >= w_dvs);
        assign n_rem = w_ge ? (w_sh - w_dvs) : w_sh;
        assign n_q   = {w_qsrc[UW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_vsrc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k] && w_vsrc) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_zero[k] <= w_zsrc;
            end
        end
    end

    assign o_vld       = r_vld[NBIT-1];
    assign o_word.zero = r_zero[NBIT-1];
    assign o_word.u    = r_q[NBIT-1];

endmodule

`default_nettype wire

FILE: rtl/core/ecu_curve_pipe.sv
// Curve stages: pick the curve argument, take cube or fourth power,
// then scale and mirror into the eased fraction. Uses ecu_pkg.
`default_nettype none

`include "easing_curve_unit_assert.svh"

module ecu_curve_pipe
    import ecu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic              i_vld,
    input  wire t_div_word         i_word,
    output logic                   o_rdy,
    output logic                   o_vld,
    output t_curve_word            o_word,
    input  wire logic              i_rdy
);

    localparam int NST = 5;

    logic r_vld [0:NST-1];
    logic w_adv [0:NST-1];
    logic w_vsrc [0:NST-1];

    // Stage A: clamp u, choose u or 1-u
    t_frac             r_a_x;
    logic              r_a_fwd;
    logic [MODE_W-1:0] r_a_mode;
    logic              r_a_zero;
    // Stage B: square
    t_frac             r_b_sq;
    t_frac             r_b_x;
    logic              r_b_fwd;
    logic [MODE_W-1:0] r_b_mode;
    logic              r_b_zero;
    // Stage C: cube
    t_frac             r_c_cu;
    t_frac             r_c_x;
    logic              r_c_fwd;
    logic [MODE_W-1:0] r_c_mode;
    logic              r_c_zero;
    // Stage D: power used by the curve
    t_frac             r_d_p;
    logic              r_d_fwd;
    logic [MODE_W-1:0] r_d_mode;
    logic              r_d_zero;
    // Stage E: eased fraction
    t_frac             r_e_f;
    logic              r_e_zero;

    t_frac             w_uc;
    logic              w_split;
    logic              n_fwd;
    t_frac             n_x;
    t_frac             w_scaled;
    t_frac             n_f;

    // Valid chain, stages move when empty or when the next one moves
    assign w_vsrc[0] = i_vld;
    for (genvar k = 0; k < NST; k++) begin : g_flow
        if (k > 0) begin : g_src
            assign w_vsrc[k] = r_vld[k-1];
        end
        if (k == NST - 1) begin : g_last
            assign w_adv[k] = ~r_vld[k] | i_rdy;
        end else begin : g_mid
            assign w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_vsrc[k];
            end
        end
    end

    assign o_rdy = w_adv[0];

    // Clamp u at 1.0 and choose the forward or mirrored branch
    assign w_uc    = (i_word.u > FX_ONE) ? FX_ONE : i_word.u;
    assign w_split = (i_mode == MODE_INOUT_CUBIC) || (i_mode == MODE_INOUT_QUART);
    assign n_fwd   = (i_mode == MODE_IN_CUBIC) || (w_split && (w_uc < FX_HALF));
    assign n_x     = n_fwd ? w_uc : (FX_ONE - w_uc);

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && w_vsrc[0]) begin
            r_a_x    <= n_x;
            r_a_fwd  <= n_fwd;
            r_a_mode <= i_mode;
            r_a_zero <= i_word.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1] && w_vsrc[1]) begin
            r_b_sq   <= fx_mul(r_a_x, r_a_x);
            r_b_x    <= r_a_x;
            r_b_fwd  <= r_a_fwd;
            r_b_mode <= r_a_mode;
            r_b_zero <= r_a_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2] && w_vsrc[2]) begin
            r_c_cu   <= fx_mul(r_b_sq, r_b_x);
            r_c_x    <= r_b_x;
            r_c_fwd  <= r_b_fwd;
            r_c_mode <= r_b_mode;
            r_c_zero <= r_b_zero;
        end
    end

    // Fourth power only for the quartic curve
    always_ff @(posedge i_clk) begin
        if (w_adv[3] && w_vsrc[3]) begin
            r_d_p    <= (r_c_mode == MODE_INOUT_QUART) ? fx_mul(r_c_cu, r_c_x) : r_c_cu;
            r_d_fwd  <= r_c_fwd;
            r_d_mode <= r_c_mode;
            r_d_zero <= r_c_zero;
        end
    end

    // Scale the half curves by 4 or 8, then mirror the falling branch
    always_comb begin
        case (r_d_mode)
            MODE_INOUT_CUBIC: w_scaled = {r_d_p[UW-3:0], 2'b00};
            MODE_INOUT_QUART: w_scaled = {r_d_p[UW-4:0], 3'b000};
            default:          w_scaled = r_d_p;
        endcase
    end

    assign n_f = r_d_fwd ? w_scaled : (FX_ONE - w_scaled);

    always_ff @(posedge i_clk) begin
        if (w_adv[4] && w_vsrc[4]) begin
            r_e_f    <= n_f;
            r_e_zero <= r_d_zero;
        end
    end

    assign o_vld       = r_vld[NST-1];
    assign o_word.f    = r_e_f;
    assign o_word.zero = r_e_zero;

    `ECU_ASSERT_IMPLY(a_arg_in_range, i_clk, i_rst_n, r_vld[0], r_a_x <= FX_ONE)
    `ECU_ASSERT_IMPLY(a_half_arg, i_clk, i_rst_n,
        r_vld[0] && r_a_fwd && (r_a_mode == MODE_INOUT_CUBIC || r_a_mode == MODE_INOUT_QUART),
        r_a_x < FX_HALF)
    `ECU_ASSERT_IMPLY(a_frac_in_range, i_clk, i_rst_n, r_vld[NST-1], r_e_f <= FX_ONE)

endmodule

`default_nettype wire

FILE: rtl/core/ecu_scale_pipe.sv
// Scaling stages: multiply change by the fraction, round to nearest,
// add begin into the output register. Uses ecu_pkg.
`default_nettype none

module ecu_scale_pipe
    import ecu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic signed [VAL_W-1:0] i_begin,
    input  wire logic signed [VAL_W-1:0] i_change,
    input  wire logic                    i_vld,
    input  wire t_curve_word             i_word,
    output logic                         o_rdy,
    output logic                         o_vld,
    output logic signed [OUT_W-1:0]      o_value,
    input  wire logic                    i_rdy
);

    // Stage F: product
    logic                    r_f_vld;
    logic signed [PW-1:0]    r_f_prod;
    logic                    r_f_zero;
    // Stage G: rounded delta
    logic                    r_g_vld;
    logic [DLT_W-1:0]        r_g_dlt;
    logic                    r_g_zero;
    // Stage H: output register
    logic                    r_h_vld;
    logic [OUT_W-1:0]        r_h_val;

    logic                    w_adv_f;
    logic                    w_adv_g;
    logic                    w_adv_h;
    logic signed [UW:0]      w_fs;
    logic signed [PW-1:0]    n_prod;
    logic [PW-1:0]           w_rnd;
    logic [DLT_W-1:0]        w_beg_x;
    logic [DLT_W-1:0]        w_chg_x;
    logic [DLT_W-1:0]        w_sum;

    assign w_adv_h = ~r_h_vld | i_rdy;
    assign w_adv_g = ~r_g_vld | w_adv_h;
    assign w_adv_f = ~r_f_vld | w_adv_g;
    assign o_rdy   = w_adv_f;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else begin
            if (w_adv_f) begin
                r_f_vld <= i_vld;
            end
            if (w_adv_g) begin
                r_g_vld <= r_f_vld;
            end
            if (w_adv_h) begin
                r_h_vld <= r_g_vld;
            end
        end
    end

    // Signed change times unsigned fraction
    assign w_fs   = $signed({1'b0, i_word.f});
    assign n_prod = i_change * w_fs;

    always_ff @(posedge i_clk) begin
        if (w_adv_f && i_vld) begin
            r_f_prod <= n_prod;
            r_f_zero <= i_word.zero;
        end
    end

    // Add one half and drop the fraction: floor with ties upward
    assign w_rnd = r_f_prod + PW'(FX_HALF);

    always_ff @(posedge i_clk) begin
        if (w_adv_g && r_f_vld) begin
            r_g_dlt  <= w_rnd[PW-1:FRAC_BITS];
            r_g_zero <= r_f_zero;
        end
    end

    // Zero duration jumps straight to begin plus change
    assign w_beg_x = {{(DLT_W-VAL_W){i_begin[VAL_W-1]}}, i_begin};
    assign w_chg_x = {{(DLT_W-VAL_W){i_change[VAL_W-1]}}, i_change};
    assign w_sum   = w_beg_x + (r_g_zero ? w_chg_x : r_g_dlt);

    always_ff @(posedge i_clk) begin
        if (w_adv_h && r_g_vld) begin
            r_h_val <= w_sum[OUT_W-1:0];
        end
    end

    assign o_vld   = r_h_vld;
    assign o_value = $signed(r_h_val);

endmodule

`default_nettype wire

FILE: rtl/core/easing_curve_unit.sv
// Easing curve unit: begin + change * f(t/d) for cubic and quartic curves.
// Stages in order: input register, one divider stage per quotient bit,
// five curve stages, three scale stages.
// One word per cycle while not stalled; every stage holds under stall and bubbles close.
// Synchronous active-low reset clears all valid bits and the config registers.
// Top level; uses ecu_pkg, ecu_div_pipe, ecu_curve_pipe, ecu_scale_pipe.
`default_nettype none

`include "easing_curve_unit_assert.svh"

module easing_curve_unit
    import ecu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [VAL_W-1:0]        i_cfg_data,
    // Time samples
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [DUR_W-1:0]        i_elapsed_time,
    // Eased values
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_eased_value
);

    logic [MODE_W-1:0]        r_mode;
    logic signed [VAL_W-1:0]  r_begin;
    logic signed [VAL_W-1:0]  r_change;
    logic [DUR_W-1:0]         r_duration;

    logic                     w_div_rdy;
    logic                     w_div_vld;
    t_div_word                w_div_word;
    logic                     w_crv_rdy;
    logic                     w_crv_vld;
    t_curve_word              w_crv_word;
    logic                     w_scl_rdy;

    // Config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IN_CUBIC;
            r_begin    <= '0;
            r_change   <= '0;
            r_duration <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CURVE_MODE:    r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_BEGIN_VALUE:   r_begin    <= $signed(i_cfg_data);
                CFG_CHANGE_AMOUNT: r_change   <= $signed(i_cfg_data);
                CFG_DURATION:      r_duration <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    ecu_div_pipe u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_duration (r_duration),
        .i_vld      (i_valid),
        .i_time     (i_elapsed_time),
        .o_rdy      (w_div_rdy),
        .o_vld      (w_div_vld),
        .o_word     (w_div_word),
        .i_rdy      (w_crv_rdy)
    );

    ecu_curve_pipe u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_vld   (w_div_vld),
        .i_word  (w_div_word),
        .o_rdy   (w_crv_rdy),
        .o_vld   (w_crv_vld),
        .o_word  (w_crv_word),
        .i_rdy   (w_scl_rdy)
    );

    ecu_scale_pipe u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_begin  (r_begin),
        .i_change (r_change),
        .i_vld    (w_crv_vld),
        .i_word   (w_crv_word),
        .o_rdy    (w_scl_rdy),
        .o_vld    (o_valid),
        .o_value  (o_eased_value),
        .i_rdy    (~i_stall)
    );

    assign o_stall = ~w_div_rdy;

    // An empty output register lets the whole pipe move
    `ECU_ASSERT_NEVER(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid && o_stall)
    // Input side can only stall when the output side is stalled
    `ECU_ASSERT_IMPLY(a_stall_from_output, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

`default_nettype wire
